// ===== sv/bcld_pkg.sv =====
// ----------------------------------------------------------------------------
// bcld_pkg
// Shared widths, register indexes, reset values and stage types for the
// battery current limit derating pipeline.
// ----------------------------------------------------------------------------
package bcld_pkg;

    localparam int MV_W       = 13;
    localparam int TEMP_W     = 12;
    localparam int LIM_W      = 14;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CRIT_LOW_MV   = 3'd0,
        REG_WARN_LOW_MV   = 3'd1,
        REG_WARN_HIGH_MV  = 3'd2,
        REG_CRIT_HIGH_MV  = 3'd3,
        REG_TEMP_START    = 3'd4,
        REG_TEMP_CUTOFF   = 3'd5,
        REG_PEAK_DIS      = 3'd6,
        REG_PEAK_CHG      = 3'd7
    } cfg_idx_t;

    localparam logic [MV_W-1:0]          RST_CRIT_LOW_MV  = 13'd2800;
    localparam logic [MV_W-1:0]          RST_WARN_LOW_MV  = 13'd3200;
    localparam logic [MV_W-1:0]          RST_WARN_HIGH_MV = 13'd4100;
    localparam logic [MV_W-1:0]          RST_CRIT_HIGH_MV = 13'd4200;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_START   = 12'sd450;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_CUTOFF  = 12'sd600;
    localparam logic [LIM_W-1:0]         RST_PEAK_DIS     = 14'd4000;
    localparam logic [LIM_W-1:0]         RST_PEAK_CHG     = 14'd1500;

    typedef struct packed {
        logic [MV_W-1:0]          crit_low_mv;
        logic [MV_W-1:0]          warn_low_mv;
        logic [MV_W-1:0]          warn_high_mv;
        logic [MV_W-1:0]          crit_high_mv;
        logic signed [TEMP_W-1:0] temp_derate_start;
        logic signed [TEMP_W-1:0] temp_cutoff;
        logic [LIM_W-1:0]         peak_discharge;
        logic [LIM_W-1:0]         peak_charge;
    } cfg_t;

    // Each limit is later scaled by num / den; num never exceeds den.
    typedef struct packed {
        logic [LIM_W-1:0]  dis_val;
        logic [MV_W-1:0]   dis_num;
        logic [MV_W-1:0]   dis_den;
        logic [LIM_W-1:0]  chg_val;
        logic [MV_W-1:0]   chg_num;
        logic [MV_W-1:0]   chg_den;
        logic [TEMP_W-1:0] t_num;
        logic [TEMP_W-1:0] t_den;
    } front_t;

endpackage

// ===== sv/bcld_front.sv =====
// ----------------------------------------------------------------------------
// bcld_front
// Band classification stage: picks the scale ratio for each limit from the
// cell voltages and the hottest temperature, one register stage.
// ----------------------------------------------------------------------------
module bcld_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  bcld_pkg::cfg_t                    cfg,
    input  logic [bcld_pkg::MV_W-1:0]         lowest_cell_mv,
    input  logic [bcld_pkg::MV_W-1:0]         highest_cell_mv,
    input  logic signed [bcld_pkg::TEMP_W-1:0] hottest_cell_temp,
    output logic                              out_valid,
    output bcld_pkg::front_t                  out_data
);

    logic             valid_reg;
    bcld_pkg::front_t data_reg;
    bcld_pkg::front_t data_next;
    logic signed [bcld_pkg::TEMP_W:0] t_num_wide;
    logic signed [bcld_pkg::TEMP_W:0] t_den_wide;

    always_comb begin
        t_num_wide = {cfg.temp_cutoff[bcld_pkg::TEMP_W-1], cfg.temp_cutoff}
                   - {hottest_cell_temp[bcld_pkg::TEMP_W-1], hottest_cell_temp};
        t_den_wide = {cfg.temp_cutoff[bcld_pkg::TEMP_W-1], cfg.temp_cutoff}
                   - {cfg.temp_derate_start[bcld_pkg::TEMP_W-1], cfg.temp_derate_start};

        data_next         = '0;
        data_next.dis_val = cfg.peak_discharge;
        data_next.chg_val = cfg.peak_charge;

        // A ratio of 1/1 leaves the limit unchanged, 0/1 zeroes it.
        if (lowest_cell_mv <= cfg.crit_low_mv) begin
            data_next.dis_num = '0;
            data_next.dis_den = bcld_pkg::MV_W'(1);
        end else if (lowest_cell_mv < cfg.warn_low_mv) begin
            data_next.dis_num = lowest_cell_mv - cfg.crit_low_mv;
            data_next.dis_den = cfg.warn_low_mv - cfg.crit_low_mv;
        end else begin
            data_next.dis_num = bcld_pkg::MV_W'(1);
            data_next.dis_den = bcld_pkg::MV_W'(1);
        end

        if (highest_cell_mv >= cfg.crit_high_mv) begin
            data_next.chg_num = '0;
            data_next.chg_den = bcld_pkg::MV_W'(1);
        end else if (highest_cell_mv > cfg.warn_high_mv) begin
            data_next.chg_num = cfg.crit_high_mv - highest_cell_mv;
            data_next.chg_den = cfg.crit_high_mv - cfg.warn_high_mv;
        end else begin
            data_next.chg_num = bcld_pkg::MV_W'(1);
            data_next.chg_den = bcld_pkg::MV_W'(1);
        end

        if (hottest_cell_temp >= cfg.temp_cutoff) begin
            data_next.t_num = '0;
            data_next.t_den = bcld_pkg::TEMP_W'(1);
        end else if (hottest_cell_temp > cfg.temp_derate_start) begin
            data_next.t_num = t_num_wide[bcld_pkg::TEMP_W-1:0];
            data_next.t_den = t_den_wide[bcld_pkg::TEMP_W-1:0];
        end else begin
            data_next.t_num = bcld_pkg::TEMP_W'(1);
            data_next.t_den = bcld_pkg::TEMP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/bcld_mul.sv =====
// ----------------------------------------------------------------------------
// bcld_mul
// Two-lane multiply stage: limit times ratio numerator, registered, with the
// ratio denominator carried alongside for the divider that follows.
// ----------------------------------------------------------------------------
module bcld_mul #(
    parameter int NUM_W = 13
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [bcld_pkg::LIM_W-1:0]          a_val,
    input  logic [NUM_W-1:0]                    a_num,
    input  logic [NUM_W-1:0]                    a_den,
    input  logic [bcld_pkg::LIM_W-1:0]          b_val,
    input  logic [NUM_W-1:0]                    b_num,
    input  logic [NUM_W-1:0]                    b_den,
    output logic                                out_valid,
    output logic [bcld_pkg::LIM_W+NUM_W-1:0]    a_prod,
    output logic [NUM_W-1:0]                    a_dvs,
    output logic [bcld_pkg::LIM_W+NUM_W-1:0]    b_prod,
    output logic [NUM_W-1:0]                    b_dvs
);

    localparam int P_W = bcld_pkg::LIM_W + NUM_W;

    logic           valid_reg;
    logic [P_W-1:0] a_prod_reg;
    logic [P_W-1:0] b_prod_reg;
    logic [NUM_W-1:0] a_dvs_reg;
    logic [NUM_W-1:0] b_dvs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_prod_reg <= P_W'(a_val) * P_W'(a_num);
            b_prod_reg <= P_W'(b_val) * P_W'(b_num);
            a_dvs_reg  <= a_den;
            b_dvs_reg  <= b_den;
        end
    end

    assign out_valid = valid_reg;
    assign a_prod    = a_prod_reg;
    assign b_prod    = b_prod_reg;
    assign a_dvs     = a_dvs_reg;
    assign b_dvs     = b_dvs_reg;

endmodule

// ===== sv/bcld_div.sv =====
// ----------------------------------------------------------------------------
// bcld_div
// Two-lane pipelined restoring divider, one quotient bit per stage. The
// dividend must satisfy dividend < divisor * 2**Q_W, so the quotient fits.
// ----------------------------------------------------------------------------
module bcld_div #(
    parameter int DEN_W = 13,
    parameter int Q_W   = 14
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [DEN_W+Q_W-1:0]   a_dvd,
    input  logic [DEN_W-1:0]       a_dvs,
    input  logic [DEN_W+Q_W-1:0]   b_dvd,
    input  logic [DEN_W-1:0]       b_dvs,
    output logic                   out_valid,
    output logic [Q_W-1:0]         a_quo,
    output logic [Q_W-1:0]         b_quo
);

    localparam int W = DEN_W + Q_W;

    // The upper DEN_W bits hold the partial remainder; the lower bits hold
    // the unused dividend bits with quotient bits shifting in from below.
    logic [Q_W-1:0]   valid_reg;
    logic [W-1:0]     a_w_reg [Q_W];
    logic [W-1:0]     b_w_reg [Q_W];
    logic [DEN_W-1:0] a_d_reg [Q_W];
    logic [DEN_W-1:0] b_d_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic             v_in;
        logic [W-1:0]     a_w_in;
        logic [W-1:0]     b_w_in;
        logic [DEN_W-1:0] a_d_in;
        logic [DEN_W-1:0] b_d_in;
        logic [DEN_W:0]   a_top;
        logic [DEN_W:0]   b_top;
        logic [DEN_W:0]   a_diff;
        logic [DEN_W:0]   b_diff;
        logic [W-1:0]     a_w_next;
        logic [W-1:0]     b_w_next;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign a_w_in = a_dvd;
            assign b_w_in = b_dvd;
            assign a_d_in = a_dvs;
            assign b_d_in = b_dvs;
        end else begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign a_w_in = a_w_reg[k-1];
            assign b_w_in = b_w_reg[k-1];
            assign a_d_in = a_d_reg[k-1];
            assign b_d_in = b_d_reg[k-1];
        end

        always_comb begin
            a_top  = a_w_in[W-1:Q_W-1];
            b_top  = b_w_in[W-1:Q_W-1];
            a_diff = a_top - {1'b0, a_d_in};
            b_diff = b_top - {1'b0, b_d_in};
            if (a_top >= {1'b0, a_d_in}) begin
                a_w_next = {a_diff[DEN_W-1:0], a_w_in[Q_W-2:0], 1'b1};
            end else begin
                a_w_next = {a_top[DEN_W-1:0], a_w_in[Q_W-2:0], 1'b0};
            end
            if (b_top >= {1'b0, b_d_in}) begin
                b_w_next = {b_diff[DEN_W-1:0], b_w_in[Q_W-2:0], 1'b1};
            end else begin
                b_w_next = {b_top[DEN_W-1:0], b_w_in[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_w_reg[k] <= a_w_next;
                b_w_reg[k] <= b_w_next;
                a_d_reg[k] <= a_d_in;
                b_d_reg[k] <= b_d_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign a_quo     = a_w_reg[Q_W-1][Q_W-1:0];
    assign b_quo     = b_w_reg[Q_W-1][Q_W-1:0];

endmodule

// ===== sv/battery_current_limit_derate.sv =====
// ----------------------------------------------------------------------------
// battery_current_limit_derate
// Derates the discharge and charge current limits by cell voltage bands and
// then by the hottest cell temperature, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                          Contents
//  -------   ---------  -----------------------------  ---------------------------
//  s_        in         s_tvalid s_tready s_tdata      cell voltages, temperature
//  m_        out        m_tvalid m_tready m_tdata      discharge and charge limits
//  cfg_      in         cfg_wr_en cfg_addr cfg_wdata   derating registers
//
//  One transfer is taken every cycle unless the pipeline is stalled; a result
//  passes one band stage, then for each of the voltage and temperature scalings
//  one multiply stage and one divider stage per quotient bit (14 each).
//  The whole pipeline advances while the output register is empty or taken,
//  so a stall freezes every stage in place.
//  Reset clears the stage valid bits and loads the register defaults.
//
module battery_current_limit_derate (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [12:0] lowest_cell_mv, [25:13] highest_cell_mv,
    // [37:26] hottest_cell_temp, [39:38] zero
    input  logic [bcld_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [13:0] discharge_limit, [27:14] charge_limit, [31:28] zero
    output logic [bcld_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [bcld_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bcld_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int MV_W   = bcld_pkg::MV_W;
    localparam int TEMP_W = bcld_pkg::TEMP_W;
    localparam int LIM_W  = bcld_pkg::LIM_W;
    // Temperature ratio waits out the voltage multiply and divide.
    localparam int T_DLY  = 1 + LIM_W;

    bcld_pkg::cfg_t   cfg_reg;
    logic             en;

    logic                      front_valid;
    bcld_pkg::front_t          front_data;

    logic                      mv_valid;
    logic [LIM_W+MV_W-1:0]     mv_dis_prod;
    logic [MV_W-1:0]           mv_dis_dvs;
    logic [LIM_W+MV_W-1:0]     mv_chg_prod;
    logic [MV_W-1:0]           mv_chg_dvs;

    logic                      dv_valid;
    logic [LIM_W-1:0]          dv_dis;
    logic [LIM_W-1:0]          dv_chg;

    logic [TEMP_W-1:0]         t_num_reg [T_DLY];
    logic [TEMP_W-1:0]         t_den_reg [T_DLY];

    logic                      mt_valid;
    logic [LIM_W+TEMP_W-1:0]   mt_dis_prod;
    logic [TEMP_W-1:0]         mt_dis_dvs;
    logic [LIM_W+TEMP_W-1:0]   mt_chg_prod;
    logic [TEMP_W-1:0]         mt_chg_dvs;

    logic                      dt_valid;
    logic [LIM_W-1:0]          dt_dis;
    logic [LIM_W-1:0]          dt_chg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crit_low_mv       <= bcld_pkg::RST_CRIT_LOW_MV;
            cfg_reg.warn_low_mv       <= bcld_pkg::RST_WARN_LOW_MV;
            cfg_reg.warn_high_mv      <= bcld_pkg::RST_WARN_HIGH_MV;
            cfg_reg.crit_high_mv      <= bcld_pkg::RST_CRIT_HIGH_MV;
            cfg_reg.temp_derate_start <= bcld_pkg::RST_TEMP_START;
            cfg_reg.temp_cutoff       <= bcld_pkg::RST_TEMP_CUTOFF;
            cfg_reg.peak_discharge    <= bcld_pkg::RST_PEAK_DIS;
            cfg_reg.peak_charge       <= bcld_pkg::RST_PEAK_CHG;
        end else if (cfg_wr_en) begin
            unique case (bcld_pkg::cfg_idx_t'(cfg_addr))
                bcld_pkg::REG_CRIT_LOW_MV:  cfg_reg.crit_low_mv  <= cfg_wdata[MV_W-1:0];
                bcld_pkg::REG_WARN_LOW_MV:  cfg_reg.warn_low_mv  <= cfg_wdata[MV_W-1:0];
                bcld_pkg::REG_WARN_HIGH_MV: cfg_reg.warn_high_mv <= cfg_wdata[MV_W-1:0];
                bcld_pkg::REG_CRIT_HIGH_MV: cfg_reg.crit_high_mv <= cfg_wdata[MV_W-1:0];
                bcld_pkg::REG_TEMP_START:
                    cfg_reg.temp_derate_start <= $signed(cfg_wdata[TEMP_W-1:0]);
                bcld_pkg::REG_TEMP_CUTOFF:
                    cfg_reg.temp_cutoff <= $signed(cfg_wdata[TEMP_W-1:0]);
                bcld_pkg::REG_PEAK_DIS:     cfg_reg.peak_discharge <= cfg_wdata[LIM_W-1:0];
                bcld_pkg::REG_PEAK_CHG:     cfg_reg.peak_charge    <= cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // The last divider stage is the output register.
    assign en       = !dt_valid || m_tready;
    assign s_tready = en;

    bcld_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (s_tvalid),
        .cfg               (cfg_reg),
        .lowest_cell_mv    (s_tdata[12:0]),
        .highest_cell_mv   (s_tdata[25:13]),
        .hottest_cell_temp ($signed(s_tdata[37:26])),
        .out_valid         (front_valid),
        .out_data          (front_data)
    );

    bcld_mul #(.NUM_W(MV_W)) u_mul_volt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .a_val     (front_data.dis_val),
        .a_num     (front_data.dis_num),
        .a_den     (front_data.dis_den),
        .b_val     (front_data.chg_val),
        .b_num     (front_data.chg_num),
        .b_den     (front_data.chg_den),
        .out_valid (mv_valid),
        .a_prod    (mv_dis_prod),
        .a_dvs     (mv_dis_dvs),
        .b_prod    (mv_chg_prod),
        .b_dvs     (mv_chg_dvs)
    );

    bcld_div #(.DEN_W(MV_W), .Q_W(LIM_W)) u_div_volt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mv_valid),
        .a_dvd     (mv_dis_prod),
        .a_dvs     (mv_dis_dvs),
        .b_dvd     (mv_chg_prod),
        .b_dvs     (mv_chg_dvs),
        .out_valid (dv_valid),
        .a_quo     (dv_dis),
        .b_quo     (dv_chg)
    );

    // Delay line that keeps the temperature ratio aligned with its item.
    always_ff @(posedge aclk) begin
        if (en) begin
            t_num_reg[0] <= front_data.t_num;
            t_den_reg[0] <= front_data.t_den;
            for (int i = 1; i < T_DLY; i++) begin
                t_num_reg[i] <= t_num_reg[i-1];
                t_den_reg[i] <= t_den_reg[i-1];
            end
        end
    end

    bcld_mul #(.NUM_W(TEMP_W)) u_mul_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .a_val     (dv_dis),
        .a_num     (t_num_reg[T_DLY-1]),
        .a_den     (t_den_reg[T_DLY-1]),
        .b_val     (dv_chg),
        .b_num     (t_num_reg[T_DLY-1]),
        .b_den     (t_den_reg[T_DLY-1]),
        .out_valid (mt_valid),
        .a_prod    (mt_dis_prod),
        .a_dvs     (mt_dis_dvs),
        .b_prod    (mt_chg_prod),
        .b_dvs     (mt_chg_dvs)
    );

    bcld_div #(.DEN_W(TEMP_W), .Q_W(LIM_W)) u_div_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mt_valid),
        .a_dvd     (mt_dis_prod),
        .a_dvs     (mt_dis_dvs),
        .b_dvd     (mt_chg_prod),
        .b_dvs     (mt_chg_dvs),
        .out_valid (dt_valid),
        .a_quo     (dt_dis),
        .b_quo     (dt_chg)
    );

    assign m_tvalid = dt_valid;
    assign m_tdata  = {(bcld_pkg::M_TDATA_W - 2*LIM_W)'(0), dt_chg, dt_dis};

    // Every selected ratio is at most one, so no scaling can raise a limit.
    a_front_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        front_valid |-> (front_data.dis_num <= front_data.dis_den) &&
                        (front_data.chg_num <= front_data.chg_den) &&
                        (front_data.t_num <= front_data.t_den) &&
                        (front_data.dis_den != '0) && (front_data.chg_den != '0) &&
                        (front_data.t_den != '0))
        else $error("front stage produced a ratio above one or a zero divisor");

    // The dividers only produce a correct quotient inside their range.
    a_volt_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_valid |-> (mv_dis_prod[LIM_W+MV_W-1:LIM_W] < mv_dis_dvs) &&
                     (mv_chg_prod[LIM_W+MV_W-1:LIM_W] < mv_chg_dvs))
        else $error("voltage divider dividend out of range");

    a_temp_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mt_valid |-> (mt_dis_prod[LIM_W+TEMP_W-1:LIM_W] < mt_dis_dvs) &&
                     (mt_chg_prod[LIM_W+TEMP_W-1:LIM_W] < mt_chg_dvs))
        else $error("temperature divider dividend out of range");

endmodule

// ===== dv/bcld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_checker
// Watches the cell reading, limit and register ports of the derating block,
// predicts the discharge and charge limits of every accepted reading and
// compares each returned limit pair with the oldest prediction.
// ----------------------------------------------------------------------------
module bcld_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bcld_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bcld_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [bcld_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bcld_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              mismatches,
    output int                              outstanding,
    output int                              results_seen
);

    localparam int MV_W      = bcld_pkg::MV_W;
    localparam int TEMP_W    = bcld_pkg::TEMP_W;
    localparam int LIM_W     = bcld_pkg::LIM_W;
    localparam int S_TDATA_W = bcld_pkg::S_TDATA_W;
    localparam int M_TDATA_W = bcld_pkg::M_TDATA_W;

    typedef struct {
        logic [LIM_W-1:0] discharge;
        logic [LIM_W-1:0] charge;
    } limit_pair_t;

    bcld_pkg::cfg_t regs;
    limit_pair_t    limits_due[$];

    // Exact integer scaling, truncated; the caller guarantees den > 0.
    function automatic logic [LIM_W-1:0] scale_down(int value, int num, int den);
        longint prod;
        prod = longint'(value) * longint'(num);
        return LIM_W'(prod / den);
    endfunction

    function automatic limit_pair_t derate(logic [S_TDATA_W-1:0] item);
        int          lo_mv, hi_mv, temp;
        int          crit_lo, warn_lo, warn_hi, crit_hi, t_start, t_cut;
        int          dis, chg;
        limit_pair_t r;
        lo_mv   = item[MV_W-1:0];
        hi_mv   = item[2*MV_W-1:MV_W];
        temp    = $signed(item[2*MV_W+TEMP_W-1:2*MV_W]);
        crit_lo = regs.crit_low_mv;
        warn_lo = regs.warn_low_mv;
        warn_hi = regs.warn_high_mv;
        crit_hi = regs.crit_high_mv;
        t_start = $signed(regs.temp_derate_start);
        t_cut   = $signed(regs.temp_cutoff);
        dis     = regs.peak_discharge;
        chg     = regs.peak_charge;

        if (lo_mv <= crit_lo) begin
            dis = 0;
        end else if (lo_mv < warn_lo) begin
            dis = scale_down(dis, lo_mv - crit_lo, warn_lo - crit_lo);
        end

        if (hi_mv >= crit_hi) begin
            chg = 0;
        end else if (hi_mv > warn_hi) begin
            chg = scale_down(chg, crit_hi - hi_mv, crit_hi - warn_hi);
        end

        // Temperature scales the already truncated voltage result.
        if (temp >= t_cut) begin
            dis = 0;
            chg = 0;
        end else if (temp > t_start) begin
            dis = scale_down(dis, t_cut - temp, t_cut - t_start);
            chg = scale_down(chg, t_cut - temp, t_cut - t_start);
        end

        r.discharge = LIM_W'(dis);
        r.charge    = LIM_W'(chg);
        return r;
    endfunction

    always @(posedge aclk) begin
        limit_pair_t      want;
        logic [LIM_W-1:0] got_dis;
        logic [LIM_W-1:0] got_chg;
        if (!aresetn) begin
            regs.crit_low_mv       = bcld_pkg::RST_CRIT_LOW_MV;
            regs.warn_low_mv       = bcld_pkg::RST_WARN_LOW_MV;
            regs.warn_high_mv      = bcld_pkg::RST_WARN_HIGH_MV;
            regs.crit_high_mv      = bcld_pkg::RST_CRIT_HIGH_MV;
            regs.temp_derate_start = bcld_pkg::RST_TEMP_START;
            regs.temp_cutoff       = bcld_pkg::RST_TEMP_CUTOFF;
            regs.peak_discharge    = bcld_pkg::RST_PEAK_DIS;
            regs.peak_charge       = bcld_pkg::RST_PEAK_CHG;
            limits_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_dis = m_tdata[LIM_W-1:0];
                got_chg = m_tdata[2*LIM_W-1:LIM_W];
                if (limits_due.size() == 0) begin
                    $error("unexpected limit transfer: discharge_limit %0d charge_limit %0d",
                           got_dis, got_chg);
                    mismatches++;
                end else begin
                    want = limits_due.pop_front();
                    if (got_dis !== want.discharge) begin
                        $error("discharge_limit: expected %0d, actual %0d",
                               want.discharge, got_dis);
                        mismatches++;
                    end
                    if (got_chg !== want.charge) begin
                        $error("charge_limit: expected %0d, actual %0d", want.charge, got_chg);
                        mismatches++;
                    end
                    if (m_tdata[M_TDATA_W-1:2*LIM_W] !== '0) begin
                        $error("m_tdata padding: expected 0, actual %0h",
                               m_tdata[M_TDATA_W-1:2*LIM_W]);
                        mismatches++;
                    end
                end
            end

            // A reading taken at this edge still sees the old register values.
            if (s_tvalid && s_tready) begin
                limits_due.push_back(derate(s_tdata));
            end

            if (cfg_wr_en) begin
                unique case (bcld_pkg::cfg_idx_t'(cfg_addr))
                    bcld_pkg::REG_CRIT_LOW_MV:  regs.crit_low_mv  = cfg_wdata[MV_W-1:0];
                    bcld_pkg::REG_WARN_LOW_MV:  regs.warn_low_mv  = cfg_wdata[MV_W-1:0];
                    bcld_pkg::REG_WARN_HIGH_MV: regs.warn_high_mv = cfg_wdata[MV_W-1:0];
                    bcld_pkg::REG_CRIT_HIGH_MV: regs.crit_high_mv = cfg_wdata[MV_W-1:0];
                    bcld_pkg::REG_TEMP_START:
                        regs.temp_derate_start = cfg_wdata[TEMP_W-1:0];
                    bcld_pkg::REG_TEMP_CUTOFF:
                        regs.temp_cutoff = cfg_wdata[TEMP_W-1:0];
                    bcld_pkg::REG_PEAK_DIS:     regs.peak_discharge = cfg_wdata[LIM_W-1:0];
                    bcld_pkg::REG_PEAK_CHG:     regs.peak_charge    = cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding <= limits_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives cell readings and register settings into the current limit derating
// block under bursty input and stalling output, and reports the verdict of
// the limit checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MV_W       = bcld_pkg::MV_W;
    localparam int TEMP_W     = bcld_pkg::TEMP_W;
    localparam int LIM_W      = bcld_pkg::LIM_W;
    localparam int S_TDATA_W  = bcld_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = bcld_pkg::M_TDATA_W;
    localparam int CFG_ADDR_W = bcld_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = bcld_pkg::CFG_DATA_W;

    localparam int MV_MAX      = (1 << MV_W) - 1;
    localparam int T_MIN       = -(1 << (TEMP_W - 1));
    localparam int T_MAX       = (1 << (TEMP_W - 1)) - 1;
    localparam int PEAK_MAX    = (1 << LIM_W) - 1;
    localparam int HOLD_CYCLES = 200;
    localparam int ITEMS_PER_SETTING = 150;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_CHOKED} sink_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int             mismatches;
    int             outstanding;
    int             results_seen;
    bcld_pkg::cfg_t cur_cfg;
    int             items_sent     = 0;
    int             settings_used  = 0;
    int             burst_left     = 0;
    int             gap_max        = 6;
    bit             squeeze_req    = 1'b0;
    bit             squeeze_done   = 1'b0;

    battery_current_limit_derate dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    bcld_checker limit_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("battery_current_limit_derate regression: fail");
        $finish;
    end

    // Result side: switches between stall patterns, and once holds off long
    // enough for the whole pipeline to back up into the input.
    initial begin : limit_sink
        sink_mode_t mode;
        int         left;
        int         tick;
        mode = SINK_OPEN;
        left = 0;
        tick = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (squeeze_req && !squeeze_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                squeeze_done = 1'b1;
            end
            if (left == 0) begin
                mode = sink_mode_t'($urandom_range(0, 3));
                left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
                SINK_OPEN:     m_tready <= 1'b1;
                SINK_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
                SINK_PERIODIC: m_tready <= ((tick % 7) < 3);
                default:       m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    function automatic bcld_pkg::cfg_t settings(int cl, int wl, int wh, int ch, int ts,
                                                int tc, int pd, int pc);
        bcld_pkg::cfg_t c;
        c.crit_low_mv       = MV_W'(cl);
        c.warn_low_mv       = MV_W'(wl);
        c.warn_high_mv      = MV_W'(wh);
        c.crit_high_mv      = MV_W'(ch);
        c.temp_derate_start = TEMP_W'(ts);
        c.temp_cutoff       = TEMP_W'(tc);
        c.peak_discharge    = LIM_W'(pd);
        c.peak_charge       = LIM_W'(pc);
        return c;
    endfunction

    function automatic bcld_pkg::cfg_t random_settings();
        int cl, wh, ts;
        if ($urandom_range(0, 3) == 0) begin
            return settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
        end
        // Mostly ordered bands of realistic width, now and then only one step wide.
        cl = $urandom_range(2000, 3400);
        wh = $urandom_range(3600, 4300);
        ts = int'($urandom_range(0, 1100)) - 400;
        return settings(cl, cl + (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 900)),
                        wh, wh + (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 300)),
                        ts, ts + (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 600)),
                        $urandom_range(0, 10000), $urandom_range(0, 10000));
    endfunction

    // Random value that favors the two thresholds of a band and its inside.
    function automatic int pick_near(int a, int b, int minv, int maxv);
        int v;
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case ($urandom_range(0, 4))
            0:       v = minv + int'($urandom_range(0, maxv - minv));
            1:       v = a + int'($urandom_range(0, 4)) - 2;
            2:       v = b + int'($urandom_range(0, 4)) - 2;
            default: v = lo + int'($urandom_range(0, hi - lo));
        endcase
        if (v < minv) v = minv;
        if (v > maxv) v = maxv;
        return v;
    endfunction

    task automatic send_item(int lo_mv, int hi_mv, int temp);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({TEMP_W'(temp), MV_W'(hi_mv), MV_W'(lo_mv)});
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_random();
        send_item(pick_near(cur_cfg.crit_low_mv, cur_cfg.warn_low_mv, 0, MV_MAX),
                  pick_near(cur_cfg.warn_high_mv, cur_cfg.crit_high_mv, 0, MV_MAX),
                  pick_near(cur_cfg.temp_derate_start, cur_cfg.temp_cutoff, T_MIN, T_MAX));
    endtask

    // Waits until every predicted limit pair has come back and the pipeline
    // has had time to flush anything spurious.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic put_reg(bcld_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Unused upper write bits get random values; the block must ignore them.
    task automatic load_settings(bcld_pkg::cfg_t c);
        settle();
        put_reg(bcld_pkg::REG_CRIT_LOW_MV,  {1'($urandom), c.crit_low_mv});
        put_reg(bcld_pkg::REG_WARN_LOW_MV,  {1'($urandom), c.warn_low_mv});
        put_reg(bcld_pkg::REG_WARN_HIGH_MV, {1'($urandom), c.warn_high_mv});
        put_reg(bcld_pkg::REG_CRIT_HIGH_MV, {1'($urandom), c.crit_high_mv});
        put_reg(bcld_pkg::REG_TEMP_START,   {2'($urandom), c.temp_derate_start});
        put_reg(bcld_pkg::REG_TEMP_CUTOFF,  {2'($urandom), c.temp_cutoff});
        put_reg(bcld_pkg::REG_PEAK_DIS,     c.peak_discharge);
        put_reg(bcld_pkg::REG_PEAK_CHG,     c.peak_charge);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
        settings_used++;
    endtask

    initial begin : stimulus
        bcld_pkg::cfg_t fixed_cfg[6];
        fixed_cfg[0] = settings(0, 0, 0, 0, 0, 0, 0, 0);
        fixed_cfg[1] = settings(MV_MAX, MV_MAX, MV_MAX, MV_MAX, T_MAX, T_MAX,
                                PEAK_MAX, PEAK_MAX);
        fixed_cfg[2] = settings(3300, 3000, 4200, 4000, 600, 450, PEAK_MAX, PEAK_MAX);
        fixed_cfg[3] = settings(0, MV_MAX, 0, MV_MAX, T_MIN, T_MAX, PEAK_MAX, PEAK_MAX);
        fixed_cfg[4] = settings(3000, 3001, 4100, 4101, 449, 450, 10000, 10000);
        fixed_cfg[5] = settings(MV_MAX, 0, MV_MAX, 0, T_MAX, T_MIN, 10000, 1);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        cur_cfg = settings(bcld_pkg::RST_CRIT_LOW_MV, bcld_pkg::RST_WARN_LOW_MV,
                           bcld_pkg::RST_WARN_HIGH_MV, bcld_pkg::RST_CRIT_HIGH_MV,
                           bcld_pkg::RST_TEMP_START, bcld_pkg::RST_TEMP_CUTOFF,
                           bcld_pkg::RST_PEAK_DIS, bcld_pkg::RST_PEAK_CHG);
        settings_used = 1;
        @(posedge aclk);

        // Band edges and field extremes under the reset settings.
        send_item(0, 0, T_MIN);
        send_item(MV_MAX, MV_MAX, T_MAX);
        send_item(2800, 4200, 0);
        send_item(2801, 4199, 0);
        send_item(2799, 4201, 500);
        send_item(3000, 4150, 250);
        send_item(3199, 4101, 250);
        send_item(3200, 4100, 250);
        send_item(3600, 3600, -400);
        send_item(3600, 3600, 450);
        send_item(3600, 3600, 451);
        send_item(3600, 3600, 525);
        send_item(3600, 3600, 599);
        send_item(3600, 3600, 600);
        send_item(3600, 3600, 1500);
        send_item(3000, 4150, 525);
        send_item(5461, 2730, -1366);
        send_item(2730, 5461, 1365);

        foreach (fixed_cfg[i]) begin
            load_settings(fixed_cfg[i]);
            repeat (ITEMS_PER_SETTING) send_random();
        end

        for (int i = 0; i < 5; i++) begin
            load_settings(random_settings());
            if (i == 2) begin
                // Back-to-back readings while the result side holds off.
                gap_max = 0;
                squeeze_req = 1'b1;
                while (!squeeze_done) send_random();
                gap_max = 6;
            end
            repeat (ITEMS_PER_SETTING) send_random();
        end

        settle();
        $display("Sent %0d cell readings under %0d register settings, including empty,",
                 items_sent, settings_used);
        $display("inverted and one-step bands; %0d limit pairs checked, one %0d-cycle stall.",
                 results_seen, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("battery_current_limit_derate regression: pass");
        end else begin
            $display("battery_current_limit_derate regression: fail");
        end
        $finish;
    end

endmodule
